[hw/rtl/snr_pkg.sv]
// snr_pkg: shared constants, types and helpers for the SNR level meter.
// Used by snr_ctrl, snr_dp and snr_level_meter. No dependencies.
package snr_pkg;
   localparam int unsigned MaxSamplesDef = 65536;
   localparam int unsigned SampleBitsDef = 16;
   localparam int unsigned EnergyW       = 46;
   localparam int unsigned FieldW        = 16;
   localparam int unsigned LogW          = 24;   // signed log2 in Q.16, integer part up to 45
   localparam int unsigned DiffW         = 26;
   localparam logic [25:0] DbPerOctave   = 26'd50504453;

   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StNoiseSil = 2'd1;
   localparam logic [1:0] StSigSil   = 2'd2;
   localparam logic [1:0] StEmpty    = 2'd3;

   // datapath commands
   typedef struct packed {
      logic accum;      // take the transfer's samples in
      logic clear;      // clear accumulators
      logic fin_start;  // latch operands and start finishing work
      logic div_start;  // start the two divisions
      logic div_step;
      logic sqrt_start;
      logic sqrt_step;
      logic log_start;  // load one operand into the log unit
      logic [1:0] log_sel;
      logic log_step;
      logic log_acc;    // fold log result into difference
      logic mul_step;   // scale difference to dB
      logic out_load;
   } snr_cmd_type;

   typedef struct packed {
      logic fin_last;   // last was on the accepted transfer
   } snr_sts_type;
endpackage

[hw/rtl/snr_dp.sv]
// snr_dp: accumulators and the shared multi-cycle units (divider, square root,
// log2, dB scaling). Depends on snr_pkg; driven by snr_ctrl.
module snr_dp #(
   parameter int unsigned MAX_SAMPLES = snr_pkg::MaxSamplesDef,
   parameter int unsigned SAMPLE_BITS = snr_pkg::SampleBitsDef,
   parameter int unsigned CountW      = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  snr_pkg::snr_cmd_type      cmd,
   input  logic [15:0]               sig_smp,
   input  logic                      sig_vld,
   input  logic [15:0]               noi_smp,
   input  logic                      noi_vld,
   output logic [15:0]               sig_rms,
   output logic [15:0]               noi_rms,
   output logic [15:0]               snr_db,
   output logic [1:0]                status
);
   localparam int unsigned EW = snr_pkg::EnergyW;
   localparam int unsigned SqW = 2 * SAMPLE_BITS;
   localparam logic [EW-1:0] EMax = {EW{1'b1}};
   localparam logic [CountW-1:0] CMax = CountW'(MAX_SAMPLES);

   logic [EW-1:0]     sig_e_ff, noi_e_ff;
   logic [CountW-1:0] sig_c_ff, noi_c_ff;
   logic [EW-1:0]     sig_e_in, noi_e_in;
   logic [CountW-1:0] sig_c_in, noi_c_in;

   function automatic logic [SqW-1:0] sq_of(input logic [15:0] raw);
      logic [SAMPLE_BITS-1:0] v;
      logic [SAMPLE_BITS-1:0] mag;
      v = SAMPLE_BITS'(raw);
      mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
      // most negative value has magnitude 2^(n-1), which wraps to itself: still right unsigned
      return SqW'(mag) * SqW'(mag);
   endfunction

   function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] e, input logic [SqW-1:0] s);
      logic [EW:0] t;
      t = {1'b0, e} + (EW+1)'(s);
      return t[EW] ? EMax : t[EW-1:0];
   endfunction

   always_comb begin
      sig_e_in = sig_e_ff;
      noi_e_in = noi_e_ff;
      sig_c_in = sig_c_ff;
      noi_c_in = noi_c_ff;
      if (cmd.clear) begin
         sig_e_in = '0; noi_e_in = '0; sig_c_in = '0; noi_c_in = '0;
      end else if (cmd.accum) begin
         if (sig_vld && sig_c_ff < CMax) begin
            sig_e_in = sat_add(sig_e_ff, sq_of(sig_smp));
            sig_c_in = sig_c_ff + 1'b1;
         end
         if (noi_vld && noi_c_ff < CMax) begin
            noi_e_in = sat_add(noi_e_ff, sq_of(noi_smp));
            noi_c_in = noi_c_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_e_ff <= '0; noi_e_ff <= '0; sig_c_ff <= '0; noi_c_ff <= '0;
      end else begin
         sig_e_ff <= sig_e_in; noi_e_ff <= noi_e_in;
         sig_c_ff <= sig_c_in; noi_c_ff <= noi_c_in;
      end
   end

   // finishing operands, latched so the accumulators can clear
   logic [EW-1:0]     fe_s_ff, fe_n_ff;
   logic [CountW-1:0] fc_s_ff, fc_n_ff;
   logic [1:0]        st_ff;

   always_ff @(posedge clock) begin
      if (cmd.fin_start) begin
         fe_s_ff <= sig_e_ff; fe_n_ff <= noi_e_ff;
         fc_s_ff <= sig_c_ff; fc_n_ff <= noi_c_ff;
         if (sig_c_ff == '0 || noi_c_ff == '0) st_ff <= snr_pkg::StEmpty;
         else if (noi_e_ff == '0)             st_ff <= snr_pkg::StNoiseSil;
         else if (sig_e_ff == '0)             st_ff <= snr_pkg::StSigSil;
         else                                 st_ff <= snr_pkg::StOk;
      end
   end

   // two restoring dividers, one quotient bit a cycle, both sets at once
   logic [EW-1:0] qs_ff, qn_ff, rs_ff, rn_ff;
   logic [EW:0]   ts, tn;
   assign ts = {rs_ff, qs_ff[EW-1]} - (EW+1)'(fc_s_ff);
   assign tn = {rn_ff, qn_ff[EW-1]} - (EW+1)'(fc_n_ff);
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         qs_ff <= fe_s_ff; qn_ff <= fe_n_ff; rs_ff <= '0; rn_ff <= '0;
      end else if (cmd.div_step) begin
         if (!ts[EW]) rs_ff <= ts[EW-1:0]; else rs_ff <= {rs_ff[EW-2:0], qs_ff[EW-1]};
         if (!tn[EW]) rn_ff <= tn[EW-1:0]; else rn_ff <= {rn_ff[EW-2:0], qn_ff[EW-1]};
         qs_ff <= {qs_ff[EW-2:0], ~ts[EW]};
         qn_ff <= {qn_ff[EW-2:0], ~tn[EW]};
      end
   end

   // two digit-by-digit square roots, one result bit a cycle (23 bits)
   localparam int unsigned RW = EW / 2;
   logic [EW-1:0] xs_ff, xn_ff;
   logic [RW+1:0] ras_ff, ran_ff;
   logic [RW+3:0] rms_s_ff, rms_n_ff;
   logic [RW+3:0] trs, trn;
   logic [RW+3:0] ps, pn;
   assign ps = {rms_s_ff[RW+1:0], xs_ff[EW-1:EW-2]};
   assign pn = {rms_n_ff[RW+1:0], xn_ff[EW-1:EW-2]};
   assign trs = ps - {ras_ff, 2'b01};
   assign trn = pn - {ran_ff, 2'b01};
   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         xs_ff <= (fc_s_ff == '0) ? '0 : qs_ff;
         xn_ff <= (fc_n_ff == '0) ? '0 : qn_ff;
         ras_ff <= '0; ran_ff <= '0; rms_s_ff <= '0; rms_n_ff <= '0;
      end else if (cmd.sqrt_step) begin
         xs_ff <= {xs_ff[EW-3:0], 2'b00};
         xn_ff <= {xn_ff[EW-3:0], 2'b00};
         if (!trs[RW+3]) begin
            rms_s_ff <= trs; ras_ff <= {ras_ff[RW:0], 1'b1};
         end else begin
            rms_s_ff <= ps;  ras_ff <= {ras_ff[RW:0], 1'b0};
         end
         if (!trn[RW+3]) begin
            rms_n_ff <= trn; ran_ff <= {ran_ff[RW:0], 1'b1};
         end else begin
            rms_n_ff <= pn;  ran_ff <= {ran_ff[RW:0], 1'b0};
         end
      end
   end

   // log2 unit: priority encode on load, then one fraction bit per step
   logic [EW-1:0] lx;
   logic [5:0]    lexp;
   logic [30:0]   m_ff;
   logic [5:0]    le_ff;
   logic [15:0]   lf_ff;
   logic [61:0]   msq;
   logic [31:0]   mnx;
   logic [EW+30:0] lxw;

   always_comb begin
      case (cmd.log_sel)
         2'd0:    lx = fe_s_ff;
         2'd1:    lx = EW'(fc_n_ff);
         2'd2:    lx = fe_n_ff;
         default: lx = EW'(fc_s_ff);
      endcase
      lexp = '0;
      for (int i = 0; i < EW; i++)
         if (lx[i]) lexp = 6'(i);
      lxw = {lx, 31'd0} >> lexp;   // m in [2^30, 2^31)
   end

   assign msq = 62'(m_ff) * 62'(m_ff);
   assign mnx = msq[61:30];

   always_ff @(posedge clock) begin
      if (cmd.log_start) begin
         m_ff  <= lxw[31:1];
         le_ff <= lexp;
         lf_ff <= '0;
      end else if (cmd.log_step) begin
         m_ff  <= mnx[31] ? mnx[31:1] : mnx[30:0];
         lf_ff <= {lf_ff[14:0], mnx[31]};
      end
   end

   // signed difference of the four logs in Q.16
   logic signed [snr_pkg::DiffW-1:0] d_ff;
   logic [snr_pkg::DiffW-1:0] lval;
   logic [1:0] sel_ff;
   assign lval = {4'd0, le_ff, lf_ff};
   always_ff @(posedge clock) begin
      if (cmd.fin_start) d_ff <= '0;
      else if (cmd.log_acc)
         d_ff <= (sel_ff[1]) ? d_ff - $signed(lval) : d_ff + $signed(lval);
      if (cmd.log_start) sel_ff <= cmd.log_sel;
   end

   // dB scaling: one 26x26 multiply, registered, then round and saturate
   logic [51:0] prod_ff;
   logic        neg_ff;
   logic [25:0] dmag;
   logic [20:0] q;
   assign dmag = d_ff[snr_pkg::DiffW-1] ? 26'(-d_ff) : 26'(d_ff);
   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         prod_ff <= 52'(dmag) * 52'(snr_pkg::DbPerOctave);
         neg_ff  <= d_ff[snr_pkg::DiffW-1];
      end
   end
   logic [52:0] rnd;
   assign rnd = {1'b0, prod_ff} + 53'h8000_0000;
   assign q = rnd[52:32];

   logic [15:0] db_val;
   always_comb begin
      if (neg_ff) db_val = (q > 21'd32768) ? 16'h8000 : 16'(-q);
      else        db_val = (q > 21'd32767) ? 16'h7fff : q[15:0];
   end

   function automatic logic [15:0] rms_sat(input logic [RW+1:0] r);
      return (r > (RW+2)'(16'hffff)) ? 16'hffff : r[15:0];
   endfunction

   logic [15:0] sig_rms_ff, noi_rms_ff, snr_db_ff;
   logic [1:0]  status_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sig_rms_ff <= rms_sat(ras_ff);
         noi_rms_ff <= rms_sat(ran_ff);
         status_ff  <= st_ff;
         case (st_ff)
            snr_pkg::StEmpty:    snr_db_ff <= '0;
            snr_pkg::StNoiseSil: snr_db_ff <= 16'h7fff;
            snr_pkg::StSigSil:   snr_db_ff <= 16'h8000;
            default:             snr_db_ff <= db_val;
         endcase
      end
   end

   assign sig_rms = sig_rms_ff;
   assign noi_rms = noi_rms_ff;
   assign snr_db  = snr_db_ff;
   assign status  = status_ff;
endmodule

[hw/rtl/snr_ctrl.sv]
// snr_ctrl: sequencer for accumulate and the finishing work.
// Depends on snr_pkg; commands snr_dp.
module snr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_fire,
   input  snr_pkg::snr_sts_type sts,
   input  logic                 out_taken,
   output logic                 in_ready,
   output logic                 out_valid,
   output snr_pkg::snr_cmd_type cmd
);
   localparam logic [2:0] S_ACC = 3'd0, S_DIV = 3'd1, S_SQRT = 3'd2, S_LOGL = 3'd3,
                          S_LOGS = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6, S_HOLD = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;

   assign in_ready  = (state_ff == S_ACC);
   assign out_valid = (state_ff == S_HOLD);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; sel_in = sel_ff;
      cmd = '0;
      cmd.log_sel = sel_ff;
      case (state_ff)
         S_ACC: begin
            cmd.accum = in_fire;
            if (in_fire && sts.fin_last) begin
               state_in = S_DIV; cnt_in = '0;
            end
         end
         S_DIV: begin
            if (cnt_ff == 6'd0) begin
               cmd.fin_start = 1'b1; cnt_in = 6'd1;
            end else if (cnt_ff == 6'd1) begin
               cmd.clear = 1'b1; cmd.div_start = 1'b1; cnt_in = 6'd2;
            end else begin
               cmd.div_step = 1'b1; cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 6'd47) begin
                  state_in = S_SQRT; cnt_in = '0;
               end
            end
         end
         S_SQRT: begin
            if (cnt_ff == 6'd0) cmd.sqrt_start = 1'b1;
            else cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd23) begin
               state_in = S_LOGL; sel_in = '0;
            end
         end
         S_LOGL: begin
            cmd.log_start = 1'b1; cnt_in = '0; state_in = S_LOGS;
         end
         S_LOGS: begin
            if (cnt_ff == 6'd16) begin
               cmd.log_acc = 1'b1; sel_in = sel_ff + 1'b1;
               state_in = (sel_ff == 2'd3) ? S_MUL : S_LOGL;
            end else begin
               cmd.log_step = 1'b1; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1; state_in = S_OUT;
         end
         S_OUT: begin
            cmd.out_load = 1'b1; state_in = S_HOLD;
         end
         S_HOLD: if (out_taken) state_in = S_ACC;
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC; cnt_ff <= '0; sel_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; sel_ff <= sel_in;
      end
   end
endmodule

[hw/rtl/snr_level_meter.sv]
// snr_level_meter: top level of the RMS and SNR meter.
// Depends on snr_pkg, snr_ctrl and snr_dp.
//
//  channel  | dir | tdata fields (low bit first)                | tuser / tlast
//  req_     | in  | signal_sample, signal_valid, noise_sample,  | last on tlast
//           |     | noise_valid (34 bits, padded to 40)         |
//  rsp_     | out | signal_rms, noise_rms, snr_db, status       | none
//
// A transfer without last is taken and accumulated, and req_tready stays high. A
// last transfer starts the finishing work (operand latch, then accumulator clear
// and divider load, 46 division steps, the square root steps, four log2 passes on
// the one shared squaring multiplier, one scale multiply, one output load), then
// the result waits in its register until taken; req_tready is low meanwhile.
// Reset is synchronous and clears the accumulators.
module snr_level_meter #(
   parameter int unsigned MAX_SAMPLES = snr_pkg::MaxSamplesDef,
   parameter int unsigned SAMPLE_BITS = snr_pkg::SampleBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // signal_sample, signal_valid, noise_sample, noise_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // signal_rms, noise_rms, snr_db, status
);
   snr_pkg::snr_cmd_type cmd;
   snr_pkg::snr_sts_type sts;
   logic in_fire;
   logic [15:0] sig_rms, noi_rms, snr_db;
   logic [1:0]  status;

   assign in_fire = req_tvalid && req_tready;
   assign sts.fin_last = req_tlast;

   snr_ctrl u_ctrl (
      .clock, .reset, .in_fire, .sts,
      .out_taken(rsp_tvalid && rsp_tready),
      .in_ready(req_tready), .out_valid(rsp_tvalid), .cmd
   );

   snr_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock, .reset, .cmd,
      .sig_smp(req_tdata[15:0]), .sig_vld(req_tdata[16]),
      .noi_smp(req_tdata[32:17]), .noi_vld(req_tdata[33]),
      .sig_rms, .noi_rms, .snr_db, .status
   );

   assign rsp_tdata = {6'd0, status, snr_db, noi_rms, sig_rms};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed before transfer");
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      in_fire && req_tlast |=> !req_tready) else $error("finish not started");
endmodule
